>>> rtl/ogi_pkg.sv
`timescale 1ns / 1ps

package ogi_pkg;

  // item field widths
  localparam int CMD_W       = 2;
  localparam int POS_W       = 7;
  localparam int CELL_W      = 14;
  localparam int DIAM_W      = 8;
  localparam int OUT_COUNT_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // command codes; every other code reads a cell
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

  typedef enum logic [1:0] {
    ADDR_CLEAR = 2'd0,
    ADDR_CELL  = 2'd1,
    ADDR_WIN   = 2'd2,
    ADDR_OUT   = 2'd3
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_ZERO  = 2'd0,
    WD_BLOCK = 2'd1,
    WD_INC   = 2'd2
  } wdata_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       setup;
    logic       out_addr;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wd_sel;
    logic       win_step;
    logic       clear_step;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_remove;
    logic diam_zero;
    logic cell_ok;
    logic win_empty;
    logic win_last;
    logic clear_done;
  } dp_stat_t;

endpackage

>>> rtl/ogi_ifs.sv
`timescale 1ns / 1ps

interface ogi_op_if import ogi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [CELL_W-1:0] obstacle_cell;
  logic [DIAM_W-1:0] safety_diameter;

  modport source(output valid, command, pos_x, pos_y, obstacle_cell, safety_diameter,
                 input ready);
  modport sink(input valid, command, pos_x, pos_y, obstacle_cell, safety_diameter,
               output ready);
endinterface

interface ogi_res_if import ogi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_COUNT_W-1:0] cell_count;
  logic                   cell_blocked;

  modport source(output valid, cell_count, cell_blocked, input ready);
  modport sink(input valid, cell_count, cell_blocked, output ready);
endinterface

interface ogi_cfg_if import ogi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/ogi_ctrl.sv
`timescale 1ns / 1ps

module ogi_ctrl import ogi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  output logic     op_ready,
  output logic     res_valid,
  input  logic     res_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_SETUP    = 12'b0000_0000_0100,
    S_DISPATCH = 12'b0000_0000_1000,
    S_BLK_RD   = 12'b0000_0001_0000,
    S_BLK_WR   = 12'b0000_0010_0000,
    S_CELL_CLR = 12'b0000_0100_0000,
    S_WIN_RD   = 12'b0000_1000_0000,
    S_WIN_WR   = 12'b0001_0000_0000,
    S_OUT_ADDR = 12'b0010_0000_0000,
    S_OUT_RD   = 12'b0100_0000_0000,
    S_RESULT   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  state_t win_entry;
  logic   res_valid_next;

  // first state of a window walk, or straight to the read-back if empty
  always_comb begin
    if (stat.win_empty) begin
      win_entry = S_OUT_ADDR;
    end else if (stat.is_add) begin
      win_entry = S_WIN_RD;
    end else begin
      win_entry = S_WIN_WR;
    end
  end

  always_comb begin
    state_next     = state;
    op_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = ADDR_CELL;
    cmd.wr_sel     = ADDR_CELL;
    cmd.wd_sel     = WD_ZERO;
    case (state)
      S_CLEAR: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = ADDR_CLEAR;
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.is_add) begin
          if (stat.cell_ok) begin
            state_next = S_BLK_RD;
          end else if (stat.diam_zero) begin
            state_next = S_OUT_ADDR;
          end else begin
            state_next = win_entry;
          end
        end else if (stat.is_remove) begin
          if (!stat.diam_zero) begin
            state_next = win_entry;
          end else if (stat.cell_ok) begin
            state_next = S_CELL_CLR;
          end else begin
            state_next = S_OUT_ADDR;
          end
        end else begin
          state_next = S_OUT_ADDR;
        end
      end
      S_BLK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_CELL;
        state_next = S_BLK_WR;
      end
      S_BLK_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ADDR_CELL;
        cmd.wd_sel = WD_BLOCK;
        state_next = stat.diam_zero ? S_OUT_ADDR : win_entry;
      end
      S_CELL_CLR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ADDR_CELL;
        cmd.wd_sel = WD_ZERO;
        state_next = S_OUT_ADDR;
      end
      S_WIN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_WIN;
        state_next = S_WIN_WR;
      end
      S_WIN_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = ADDR_WIN;
        cmd.wd_sel   = stat.is_add ? WD_INC : WD_ZERO;
        cmd.win_step = 1'b1;
        if (stat.win_last) begin
          state_next = S_OUT_ADDR;
        end else if (stat.is_add) begin
          state_next = S_WIN_RD;
        end
      end
      S_OUT_ADDR: begin
        cmd.out_addr = 1'b1;
        state_next   = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_OUT;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // wait until the result register is free
        if (!res_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

>>> rtl/ogi_dp.sv
`timescale 1ns / 1ps

module ogi_dp import ogi_pkg::*; #(
  parameter int MAX_SIDE   = 128,
  parameter int COUNT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [CMD_W-1:0]       command,
  input  logic [POS_W-1:0]       pos_x,
  input  logic [POS_W-1:0]       pos_y,
  input  logic [CELL_W-1:0]      obstacle_cell,
  input  logic [DIAM_W-1:0]      safety_diameter,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic [OUT_COUNT_W-1:0] cell_count,
  output logic                   cell_blocked
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = (SW > 8) ? SW : 8;
  localparam int PW    = CW + SW;
  localparam int MW    = COUNT_BITS + 1;
  localparam int HW    = DIAM_W - 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  function automatic logic [SW-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
    logic [SW-1:0] s;
    if (v == '0) begin
      s = SW'(1);
    end else if (32'(v) > MAX_SIDE) begin
      s = SW'(MAX_SIDE);
    end else begin
      s = SW'(v);
    end
    return s;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  // store word: blocked flag on top, inflation counter below
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata;
  logic [MW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  logic [SW-1:0]     grid_w;
  logic [SW-1:0]     grid_h;
  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  x_r;
  logic [POS_W-1:0]  y_r;
  logic [CELL_W-1:0] cell_r;
  logic [DIAM_W-1:0] diam_r;

  logic [CW-1:0] sx;
  logic [CW-1:0] ex;
  logic [CW-1:0] ey;
  logic [CW-1:0] cur_x;
  logic [CW-1:0] cur_y;
  logic [AW-1:0] row_base;
  logic          win_empty;
  logic [AW-1:0] out_idx;
  logic [AW-1:0] clr_addr;

  logic [HW-1:0] half;
  logic [CW-1:0] hw;
  logic [CW-1:0] xw;
  logic [CW-1:0] yw;
  logic [CW-1:0] gwc;
  logic [CW-1:0] ghc;
  logic [CW-1:0] x_end;
  logic [CW-1:0] y_end;
  logic [CW-1:0] sx_c;
  logic [CW-1:0] sy_c;
  logic [CW-1:0] ex_c;
  logic [CW-1:0] ey_c;
  logic [CW-1:0] mul_a;
  logic [PW-1:0] prod;
  logic [AW-1:0] win_addr;
  logic [AW-1:0] cell_addr;
  logic          in_grid;
  logic [COUNT_BITS-1:0] rd_count;

  // window bounds
  always_comb begin
    half  = (diam_r[DIAM_W-1:1] == '0) ? HW'(1) : diam_r[DIAM_W-1:1];
    hw    = CW'(half);
    xw    = CW'(x_r);
    yw    = CW'(y_r);
    gwc   = CW'(grid_w);
    ghc   = CW'(grid_h);
    x_end = xw + hw;
    y_end = yw + hw;
    sx_c  = (xw > hw) ? xw - hw : '0;
    sy_c  = (yw > hw) ? yw - hw : '0;
    ex_c  = (x_end >= gwc) ? gwc - CW'(1) : x_end;
    ey_c  = (y_end >= ghc) ? ghc - CW'(1) : y_end;
  end

  // one row multiplier: window start row during setup, read-back row after
  assign mul_a     = cmd.setup ? sy_c : yw;
  assign prod      = PW'(mul_a) * PW'(grid_w);
  assign win_addr  = row_base + AW'(cur_x);
  assign cell_addr = AW'(cell_r);
  assign in_grid   = (xw < gwc) && (yw < ghc);
  assign rd_count  = rdata[COUNT_BITS-1:0];

  always_comb begin
    stat.is_add     = (cmd_r == CMD_ADD);
    stat.is_remove  = (cmd_r == CMD_REMOVE);
    stat.diam_zero  = (diam_r == '0);
    stat.cell_ok    = (32'(cell_r) < DEPTH);
    stat.win_empty  = win_empty;
    stat.win_last   = (cur_x == ex) && (cur_y == ey);
    stat.clear_done = (clr_addr == AW'(DEPTH - 1));
  end

  always_comb begin
    case (cmd.rd_sel)
      ADDR_CELL: raddr = cell_addr;
      ADDR_WIN:  raddr = win_addr;
      ADDR_OUT:  raddr = out_idx;
      default:   raddr = clr_addr;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      ADDR_CELL: waddr = cell_addr;
      ADDR_WIN:  waddr = win_addr;
      ADDR_OUT:  waddr = out_idx;
      default:   waddr = clr_addr;
    endcase
  end

  always_comb begin
    case (cmd.wd_sel)
      // a zero diameter add also bumps the obstacle counter here
      WD_BLOCK: wdata = {1'b1, stat.diam_zero ? sat_inc(rd_count) : rd_count};
      WD_INC:   wdata = {rdata[MW-1], sat_inc(rd_count)};
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w   <= clamp_side(CFG_DATA_W'(128));
      grid_h   <= clamp_side(CFG_DATA_W'(128));
      clr_addr <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_w <= clamp_side(cfg_data);
          REG_GRID_HEIGHT: grid_h <= clamp_side(cfg_data);
          default: ;
        endcase
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r  <= command;
      x_r    <= pos_x;
      y_r    <= pos_y;
      cell_r <= obstacle_cell;
      diam_r <= safety_diameter;
    end
    if (cmd.setup) begin
      sx        <= sx_c;
      ex        <= ex_c;
      ey        <= ey_c;
      cur_x     <= sx_c;
      cur_y     <= sy_c;
      row_base  <= AW'(prod);
      win_empty <= (sx_c > ex_c) || (sy_c > ey_c);
    end else if (cmd.win_step) begin
      if (cur_x == ex) begin
        cur_x    <= sx;
        cur_y    <= cur_y + CW'(1);
        row_base <= row_base + AW'(grid_w);
      end else begin
        cur_x <= cur_x + CW'(1);
      end
    end
    if (cmd.out_addr) begin
      out_idx <= AW'(prod) + AW'(x_r);
    end
    if (cmd.out_load) begin
      cell_count   <= in_grid ? OUT_COUNT_W'(rd_count) : '0;
      cell_blocked <= in_grid & rdata[MW-1];
    end
  end

endmodule

>>> rtl/occupancy_grid_obstacle_inflation_core.sv
`timescale 1ns / 1ps
// Steps, accept to result load: add reads then writes each window cell (none for a zero
// diameter), remove writes each cell cleared, and a read only reads back its cell.
// Throughput: one item at a time; the next item is taken in the cycle after the result
// loads, also while that result still waits on res.ready.
// Reset (rst, synchronous) starts a clearing pass that zeroes the whole store;
// op.ready stays low until it ends. cfg is always ready.
module occupancy_grid_obstacle_inflation_core import ogi_pkg::*; #(
  parameter int MAX_SIDE   = 128,
  parameter int COUNT_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  ogi_op_if.sink    op,
  ogi_res_if.source res,
  ogi_cfg_if.sink   cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  ogi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op.valid),
    .op_ready  (op.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ogi_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .command         (op.command),
    .pos_x           (op.pos_x),
    .pos_y           (op.pos_y),
    .obstacle_cell   (op.obstacle_cell),
    .safety_diameter (op.safety_diameter),
    .cmd             (cmd),
    .stat            (stat),
    .cell_count      (res.cell_count),
    .cell_blocked    (res.cell_blocked)
  );

endmodule

>>> rtl/ogi_checker.sv
`timescale 1ns / 1ps

module ogi_checker import ogi_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   op_valid,
  input logic                   op_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [OUT_COUNT_W-1:0] cell_count,
  input logic                   cell_blocked,
  input logic                   cfg_ready
);

  // the clearing pass keeps the item side closed right after reset
  a_clear_blocks_items: assert property (@(posedge clk) rst |=> !op_ready)
    else $error("item accepted during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> !op_ready)
    else $error("second item accepted while busy");

  // no result can appear in the cycle after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> !$rose(res_valid))
    else $error("result before item was processed");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(cell_count) && $stable(cell_blocked)))
    else $error("stalled item changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind occupancy_grid_obstacle_inflation_core ogi_checker u_ogi_checker (
  .clk          (clk),
  .rst          (rst),
  .op_valid     (op.valid),
  .op_ready     (op.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .cell_count   (res.cell_count),
  .cell_blocked (res.cell_blocked),
  .cfg_ready    (cfg.ready)
);
